// ----- hdl/opdt_pkg.sv -----
`timescale 1ns / 1ps

package opdt_pkg;

    // Packet geometry and destuffing rules.
    localparam int IN_BITS    = 64;
    localparam int OUT_BITS   = 49;
    localparam int RUN_LIMIT  = 5;
    localparam int CHUNK_BITS = 8;
    localparam int STAGES     = IN_BITS / CHUNK_BITS;
    localparam int POS_W      = $clog2(OUT_BITS + 1);
    localparam int ONES_W     = $clog2(RUN_LIMIT);

    // Field layout of the destuffed word.
    localparam int ID_LSB    = 0;
    localparam int ID_W      = 32;
    localparam int SELL_BIT  = 32;
    localparam int QTY_LSB   = 33;
    localparam int QTY_W     = 8;
    localparam int PRICE_LSB = 41;
    localparam int PRICE_W   = 8;
    localparam int PROD_W    = QTY_W + PRICE_W;

    // Running total.
    localparam int DEF_TOTAL_BITS = 48;
    localparam int TOTAL_OUT_W    = 48;

    // Queue between the destuffing pipeline and the accumulator.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [IN_BITS-1:0] packet_word;
        logic               last_of_batch;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]        stock_id;
        logic                   is_sell;
        logic [QTY_W-1:0]       quantity;
        logic [PRICE_W-1:0]     price;
        logic [TOTAL_OUT_W-1:0] running_total;
        logic                   batch_end;
    } t_out_item;

    // Scan state carried from one pipeline stage to the next.
    typedef struct packed {
        logic [OUT_BITS-1:0] word;
        logic [POS_W-1:0]    pos;
        logic [ONES_W-1:0]   ones;
        logic                drop;
    } t_scan;

    // Decoded order as it waits in the queue.
    typedef struct packed {
        logic [ID_W-1:0]    stock_id;
        logic               is_sell;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
        logic               last;
    } t_dec_item;

    typedef struct packed {
        logic      valid;
        t_dec_item item;
    } t_dec_beat;

    // Advances the destuffing scan over one chunk of input bits, lowest first.
    function automatic t_scan scan_chunk(t_scan s, logic [CHUNK_BITS-1:0] bits);
        t_scan r;
        r = s;
        for (int j = 0; j < CHUNK_BITS; j++) begin
            if (r.pos < POS_W'(OUT_BITS)) begin
                if (r.drop) begin
                    r.drop = 1'b0;
                end else if (bits[j]) begin
                    r.word[r.pos] = 1'b1;
                    r.pos = r.pos + 1'b1;
                    if (r.ones == ONES_W'(RUN_LIMIT - 1)) begin
                        r.ones = '0;
                        r.drop = 1'b1;
                    end else begin
                        r.ones = r.ones + 1'b1;
                    end
                end else begin
                    r.ones = '0;
                    r.pos  = r.pos + 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_dec_item decode(logic [OUT_BITS-1:0] word, logic last);
        t_dec_item d;
        d.stock_id = word[ID_LSB +: ID_W];
        d.is_sell  = word[SELL_BIT];
        d.quantity = word[QTY_LSB +: QTY_W];
        d.price    = word[PRICE_LSB +: PRICE_W];
        d.last     = last;
        return d;
    endfunction

endpackage

// ----- hdl/opdt_front.sv -----
`timescale 1ns / 1ps

module opdt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  opdt_pkg::t_in_item   i_in_item,
    output opdt_pkg::t_dec_beat  o_push,
    input  logic                 i_queue_full
);
    import opdt_pkg::*;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] r_last;
    t_scan             r_scan [STAGES];
    logic [IN_BITS-1:0] r_raw [STAGES];
    t_scan             n_scan [STAGES];
    logic              adv;

    // The whole pipeline moves together; it only holds when the last stage
    // has an item that the queue cannot take.
    assign adv        = !(r_v[STAGES-1] && i_queue_full);
    assign o_in_ready = adv;

    always_comb begin
        n_scan[0] = scan_chunk('0, i_in_item.packet_word[CHUNK_BITS-1:0]);
        for (int k = 1; k < STAGES; k++) begin
            n_scan[k] = scan_chunk(r_scan[k-1], r_raw[k-1][k*CHUNK_BITS +: CHUNK_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[STAGES-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_scan[0] <= n_scan[0];
            r_raw[0]  <= i_in_item.packet_word;
            r_last[0] <= i_in_item.last_of_batch;
            for (int k = 1; k < STAGES; k++) begin
                r_scan[k] <= n_scan[k];
                r_raw[k]  <= r_raw[k-1];
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign o_push.valid = r_v[STAGES-1] && !i_queue_full;
    assign o_push.item  = decode(r_scan[STAGES-1].word, r_last[STAGES-1]);

endmodule

// ----- hdl/opdt_queue.sv -----
`timescale 1ns / 1ps

module opdt_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  opdt_pkg::t_dec_beat  i_push,
    output logic                 o_full,
    output opdt_pkg::t_dec_beat  o_head,
    input  logic                 i_pop
);
    import opdt_pkg::*;

    t_dec_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign push = i_push.valid;
    assign pop  = i_pop;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push.item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not rise on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not fall on pop");
`endif

endmodule

// ----- hdl/opdt_back.sv -----
`timescale 1ns / 1ps

module opdt_back #(
    parameter int TOTAL_BITS = opdt_pkg::DEF_TOTAL_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  opdt_pkg::t_dec_beat  i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output opdt_pkg::t_out_item  o_out_item
);
    import opdt_pkg::*;

    localparam int SUM_W = TOTAL_BITS + 1;
    localparam int EXT_W = (TOTAL_BITS > TOTAL_OUT_W) ? TOTAL_BITS : TOTAL_OUT_W;

    logic                  r_b1_v;
    t_dec_item             r_b1;
    logic [PROD_W-1:0]     r_prod;
    logic [TOTAL_BITS-1:0] r_total;
    logic                  r_out_v;
    t_out_item             r_out;

    logic                  out_adv;
    logic                  b1_take;
    logic                  load_out;
    logic [SUM_W-1:0]      sum_wide;
    logic [TOTAL_BITS-1:0] n_sum;
    logic [EXT_W-1:0]      sum_ext;

    assign out_adv  = !r_out_v || i_out_ready;
    assign load_out = r_b1_v && out_adv;
    assign b1_take  = !r_b1_v || out_adv;
    assign o_pop    = i_head.valid && b1_take;

    // Saturating add: a carry out of the total's width pins it at all ones.
    assign sum_wide = {1'b0, r_total} + SUM_W'(r_prod);
    assign n_sum    = sum_wide[TOTAL_BITS] ? '1 : sum_wide[TOTAL_BITS-1:0];
    assign sum_ext  = EXT_W'(n_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_total <= '0;
        end else begin
            if (b1_take) begin
                r_b1_v <= i_head.valid;
            end
            if (out_adv) begin
                r_out_v <= r_b1_v;
            end
            if (load_out) begin
                r_total <= r_b1.last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_take) begin
            r_b1   <= i_head.item;
            r_prod <= PROD_W'(i_head.item.quantity) * PROD_W'(i_head.item.price);
        end
        if (load_out) begin
            r_out.stock_id      <= r_b1.stock_id;
            r_out.is_sell       <= r_b1.is_sell;
            r_out.quantity      <= r_b1.quantity;
            r_out.price         <= r_b1.price;
            r_out.running_total <= sum_ext[TOTAL_OUT_W-1:0];
            r_out.batch_end     <= r_b1.last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_b1.last) |=> r_total == '0)
        else $error("total not cleared after batch end");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && !r_b1.last) |=> r_total >= $past(r_total))
        else $error("running total decreased within a batch");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_ready) |=> $stable(r_total))
        else $error("total moved while the output was stalled");
`endif

endmodule

// ----- hdl/order_packet_destuff_and_total_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_item   (opdt_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_item  (opdt_pkg::t_out_item)
//
// One item is accepted per cycle and one result leaves per cycle when the
// output side takes them. An accepted item passes through registers in
// order: the first of eight destuffing stages (eight input bits per stage)
// through the last, then the queue, then the register that holds the
// quantity times price product, and then the output register, which takes
// the saturating accumulate.
// Reset is synchronous and active low; it empties the pipeline and the queue
// and clears the running total.
// A stalled output holds the accumulator; the destuffing pipeline keeps
// running until the queue fills, and only then, with an item waiting in its
// last stage, does o_in_ready drop.
module order_packet_destuff_and_total_core #(
    parameter int TOTAL_BITS = opdt_pkg::DEF_TOTAL_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  opdt_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output opdt_pkg::t_out_item  o_out_item
);
    import opdt_pkg::*;

    // Decoded orders handed from the destuffer to the queue, and from the
    // queue head to the accumulator.
    t_dec_beat push;
    t_dec_beat head;
    logic      queue_full;
    logic      pop;

    // The front destuffs each packet over eight stages and decodes its fields.
    opdt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push       (push),
        .i_queue_full (queue_full)
    );

    // The queue lets the front keep working while the output is stalled.
    opdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // The back multiplies, accumulates the batch total and drives the output.
    opdt_back #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- bench/tb_order_packet_destuff_and_total_core.sv -----
`timescale 1ns / 1ps

module tb_order_packet_destuff_and_total_core;

    import opdt_pkg::*;

    // The narrowest total width; the output pads it with zeros to 48 bits.
    localparam int TB_TOTAL_BITS = 32;
    localparam longint unsigned SUM_CAP = {64{1'b1}} >> (64 - TB_TOTAL_BITS);
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 30;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out_item;

    // Items waiting to be offered, and the decoded orders the block still owes us.
    t_in_item  pending_items[$];
    t_out_item expected_orders[$];
    t_out_item oldest_order;

    // Running total of the current batch as the block should see it.
    logic [63:0] batch_total = '0;

    int failures = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_served = 0;
    int hold_left = 0;

    order_packet_destuff_and_total_core #(
        .TOTAL_BITS(TB_TOTAL_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Removes the stuffed bits: after five ones in a row the next wire bit is
    // skipped, whatever its value. The scan ends at 49 output bits or at the
    // end of the 64 wire bits, and unfilled output bits stay zero.
    function automatic logic [48:0] unstuff_packet(logic [63:0] raw);
        logic [48:0] word;
        int          pos;
        int          run;
        logic        skip;
        word = '0;
        pos  = 0;
        run  = 0;
        skip = 1'b0;
        for (int i = 0; i < 64 && pos < 49; i++) begin
            if (skip) begin
                skip = 1'b0;
            end else if (raw[i]) begin
                word[pos] = 1'b1;
                pos++;
                run++;
                if (run == 5) begin
                    run  = 0;
                    skip = 1'b1;
                end
            end else begin
                run = 0;
                pos++;
            end
        end
        return word;
    endfunction

    // Decodes one accepted item and folds its trade value into the batch total.
    function automatic t_out_item price_order(t_in_item item);
        t_out_item   r;
        logic [48:0] word;
        logic [63:0] trade;
        logic [63:0] sum;
        word = unstuff_packet(item.packet_word);
        r.stock_id = word[31:0];
        r.is_sell  = word[32];
        r.quantity = word[40:33];
        r.price    = word[48:41];
        trade = 64'(r.quantity) * 64'(r.price);
        sum   = batch_total & SUM_CAP;
        if (trade > SUM_CAP - sum) begin
            sum = SUM_CAP;
        end else begin
            sum = sum + trade;
        end
        r.running_total = sum[47:0];
        r.batch_end     = item.last_of_batch;
        batch_total     = item.last_of_batch ? 64'd0 : sum;
        return r;
    endfunction

    // Builds a wire packet from a destuffed word. Each inserted bit takes a
    // random value, since the receiver drops it either way, and the wire bits
    // past the stuffed stream are random too.
    function automatic logic [63:0] stuff_order(logic [31:0] id, logic sell,
                                                logic [7:0] qty, logic [7:0] prc);
        logic [48:0] word;
        logic [63:0] raw;
        int          n;
        int          run;
        word = {prc, qty, sell, id};
        raw  = {$urandom, $urandom};
        n    = 0;
        run  = 0;
        for (int p = 0; p < 49; p++) begin
            raw[n] = word[p];
            n++;
            if (word[p]) begin
                run++;
                if (run == 5) begin
                    run    = 0;
                    raw[n] = 1'($urandom_range(1));
                    n++;
                end
            end else begin
                run = 0;
            end
        end
        return raw;
    endfunction

    // Byte values lean toward the extremes so the products hit their corners.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_packet(logic [63:0] raw, logic last);
        t_in_item item;
        item.packet_word   = raw;
        item.last_of_batch = last;
        pending_items.insert(pending_items.size(), item);
    endtask

    task automatic queue_random_items(int count);
        logic [31:0] id;
        logic [63:0] raw;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) < 8) begin
                case ($urandom_range(9))
                    0: id = 32'h0000_0000;
                    1: id = 32'hFFFF_FFFF;
                    default: id = $urandom;
                endcase
                raw = stuff_order(id, 1'($urandom_range(1)), pick_byte(), pick_byte());
            end else begin
                // Raw noise: any 64-bit pattern is a legal packet.
                raw = {$urandom, $urandom};
            end
            queue_packet(raw, $urandom_range(7) == 0);
        end
    endtask

    // Waits at falling edges until every item is sent and every result is back.
    task automatic drain_block();
        while (pending_items.size() != 0 || in_valid || expected_orders.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            failures++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Sender: a new item goes out only once the previous one has been taken,
    // so valid never drops while an item is on offer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off each time the
    // stimulus raises the token, so the queue fills and the input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_token) begin
            hold_served <= hold_token;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: results are checked before the item accepted at the same edge
    // is predicted, so a result can never be matched against its own item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (expected_orders.size() == 0) begin
                    failures++;
                    $error("result arrived with no item outstanding");
                end else begin
                    oldest_order = expected_orders.pop_front();
                    check_field("stock_id", 64'(oldest_order.stock_id),
                                64'(o_out_item.stock_id));
                    check_field("is_sell", 64'(oldest_order.is_sell),
                                64'(o_out_item.is_sell));
                    check_field("quantity", 64'(oldest_order.quantity),
                                64'(o_out_item.quantity));
                    check_field("price", 64'(oldest_order.price),
                                64'(o_out_item.price));
                    check_field("running_total", 64'(oldest_order.running_total),
                                64'(o_out_item.running_total));
                    check_field("batch_end", 64'(oldest_order.batch_end),
                                64'(o_out_item.batch_end));
                end
            end
            if (in_valid && o_in_ready) begin
                expected_orders.insert(expected_orders.size(), price_order(in_item));
            end
        end
    end

    // Stimulus. Reset is released at a rising edge; all later work happens at
    // falling edges, away from the rising edges where the driver and monitor act.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one: the sender rarely idles, the receiver mostly does.
        send_idle_pct = 6;
        recv_idle_pct = 84;

        // Directed: empty and all-ones packets, field extremes, stuffed bits
        // of either value, and a batch end followed by a cleared total.
        queue_packet(64'h0000_0000_0000_0000, 1'b0);
        queue_packet(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_packet(stuff_order(32'h0000_0000, 1'b0, 8'h00, 8'h00), 1'b0);
        queue_packet(stuff_order(32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF), 1'b0);
        queue_packet(stuff_order(32'hFFFF_FFFF, 1'b0, 8'h00, 8'hFF), 1'b0);
        queue_packet(stuff_order(32'h0000_0000, 1'b1, 8'hFF, 8'h00), 1'b0);
        queue_packet(stuff_order(32'h5555_AAAA, 1'b0, 8'h01, 8'h01), 1'b0);
        queue_packet(stuff_order($urandom, 1'b1, 8'hFF, 8'hFF), 1'b1);
        queue_packet(stuff_order($urandom, 1'b0, 8'h03, 8'h07), 1'b0);
        queue_packet(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_packet(64'h5555_5555_5555_5555, 1'b0);
        queue_packet(64'h8000_0000_0000_0000, 1'b0);
        queue_packet(64'h7DF7_DF7D_F7DF_7DF7, 1'b0);
        queue_packet(64'h0000_0000_0000_0000, 1'b1);
        queue_packet({$urandom, $urandom}, 1'b1);
        queue_packet(stuff_order(32'h8000_0001, 1'b1, 8'h80, 8'h7F), 1'b0);
        drain_block();

        queue_random_items(350);
        drain_block();

        // Phase two: the sender mostly idles, the receiver rarely does.
        send_idle_pct = 84;
        recv_idle_pct = 6;
        queue_random_items(200);
        drain_block();

        // Phase three: no idling, with one long receiver hold-off while the
        // sender keeps offering items.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_items(150);
        hold_token = hold_token + 1;
        drain_block();

        // A batch of maximum trades closes, and the next total starts over.
        for (int k = 0; k < 4; k++) begin
            queue_packet(stuff_order($urandom, 1'($urandom_range(1)), 8'hFF, 8'hFF), 1'b0);
        end
        queue_packet(stuff_order($urandom, 1'b1, 8'hFF, 8'hFF), 1'b1);
        queue_packet(stuff_order($urandom, 1'b0, 8'h02, 8'h03), 1'b0);
        queue_packet(stuff_order($urandom, 1'b0, 8'hFF, 8'hFF), 1'b1);
        drain_block();

        // Give a stray late result the chance to show up.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (failures == 0 && expected_orders.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/opdt_pkg.sv
hdl/opdt_front.sv
hdl/opdt_queue.sv
hdl/opdt_back.sv
hdl/order_packet_destuff_and_total_core.sv
bench/tb_order_packet_destuff_and_total_core.sv
